// File: design/bfdh_pkg.sv
// Package for the double-hash bloom filter.
// Holds request codes, hash constants and shared types; no dependencies.
package bfdh_pkg;
    localparam logic [1:0] REQ_CHECK = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [31:0] MM_M       = 32'h5bd1e995;
    localparam logic [31:0] FIRST_SEED = 32'h9747b28c;

    localparam logic [16:0] BIT_COUNT_RST  = 17'd57344;
    localparam logic [4:0]  HASH_COUNT_RST = 5'd9;

    localparam logic CFG_BIT_COUNT  = 1'b0;
    localparam logic CFG_HASH_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
        logic [4:0]  key_len;
    } req_t;

    typedef struct packed {
        logic present;
    } rsp_t;

    // Hash unit handshake with the sequencer
    typedef struct packed {
        logic        start;
        logic [31:0] seed;
    } hash_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hash;
    } hash_rsp_t;
endpackage

// File: design/bfdh_if.sv
// Valid/ready stream interface with a generic payload type.
// No dependencies; the payload type is a parameter.
interface bfdh_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/bfdh_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module bfdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: design/bfdh_hash.sv
// Serial MurmurHash2 unit: one multiply per cycle, one shared multiplier.
// Depends on bfdh_pkg.
module bfdh_hash
    import bfdh_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hash_cmd_t                     cmd,
    input  logic [8*MAX_KEY_BYTES-1:0]    key,
    input  logic [$clog2(MAX_KEY_BYTES+1)-1:0] len,
    output hash_rsp_t                     rsp
);
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KW = 8 * MAX_KEY_BYTES;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_K1    = 3'd1;
    localparam logic [2:0] S_K2    = 3'd2;
    localparam logic [2:0] S_H     = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_MIX   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [31:0]   h_reg, h_next;
    logic [31:0]   k_reg, k_next;
    logic [KW-1:0] key_reg, key_next;
    logic [LW-1:0] rest_reg, rest_next;
    logic [31:0]   mul_a;
    logic [31:0]   prod;
    logic [31:0]   tail;

    always_comb
    begin
        unique case (state_reg)
            S_K1, S_K2: mul_a = k_reg;
            default:    mul_a = h_reg;
        endcase
    end
    assign prod = mul_a * MM_M;

    // Remaining 1..3 tail bytes
    always_comb
    begin
        tail = 32'd0;
        if (rest_reg == LW'(3))
        begin
            tail = {8'd0, key_reg[23:0]};
        end
        else if (rest_reg == LW'(2))
        begin
            tail = {16'd0, key_reg[15:0]};
        end
        else
        begin
            tail = {24'd0, key_reg[7:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        key_next   = key_reg;
        rest_next  = rest_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    h_next     = cmd.seed ^ 32'(len);
                    key_next   = key;
                    rest_next  = len;
                    state_next = S_H;
                end
            end
            S_H:
            begin
                if (rest_reg >= LW'(4))
                begin
                    k_next     = key_reg[31:0];
                    key_next   = KW'(key_reg >> 32);
                    rest_next  = rest_reg - LW'(4);
                    state_next = S_K1;
                end
                else if (rest_reg != '0)
                begin
                    h_next     = h_reg ^ tail;
                    state_next = S_TAIL;
                end
                else
                begin
                    h_next     = h_reg ^ (h_reg >> 13);
                    state_next = S_FIN;
                end
            end
            S_K1:
            begin
                k_next     = prod ^ (prod >> 24);
                state_next = S_K2;
            end
            S_K2:
            begin
                // k = k*m; the h multiply follows in S_MIX
                k_next     = prod;
                h_next     = h_reg;
                state_next = S_MIX;
            end
            S_TAIL:
            begin
                h_next     = prod ^ (prod >> 13);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                h_next     = prod ^ (prod >> 15);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            S_MIX:
            begin
                // h = h*m ^ k
                h_next     = prod ^ k_reg;
                state_next = S_H;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg    <= h_next;
        k_reg    <= k_next;
        key_reg  <= key_next;
        rest_reg <= rest_next;
    end

    assign rsp.done = (state_reg == S_DONE);
    assign rsp.hash = h_reg;
endmodule

// File: design/bloom_filter_double_hash.sv
// Top level of the double-hash bloom filter: sequencer, probe datapath, store.
// Depends on bfdh_pkg, bfdh_if, bfdh_ram, bfdh_hash.
//
//  channel   dir  payload                               handshake
//  req       in   req_type, key_lo, key_hi, key_len     valid/ready
//  rsp       out  present                               valid/ready
//  cfg       in   cfg_we, cfg_index, cfg_wdata          write strobe
//
// One request at a time. Each hash pass mixes the key four bytes at a time,
// then any tail bytes; each probe runs issue, a 32-bit restoring modulo by
// bit_count, store read, check/write-back.
// Reset and every clear request sweep the store, one byte a cycle, over all
// (MAX_BITS+7)/8 bytes (8192 by default); no request is taken during the sweep.
// The result sits in an output register; the next request is taken once the
// result is taken, at the earliest in the same cycle.
module bloom_filter_double_hash
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS      = 65536,
    parameter int MAX_KEY_BYTES = 16,
    parameter int MAX_HASHES    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    bfdh_if.sink        req,
    bfdh_if.source      rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_wdata
);
    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KW  = 8 * MAX_KEY_BYTES;
    localparam int HW  = $clog2(MAX_HASHES + 1);
    localparam logic [31:0] MAXB = 32'(MAX_BITS);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HA    = 4'd2;
    localparam logic [3:0] S_HB    = 4'd3;
    localparam logic [3:0] S_PROBE = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [16:0] bit_count_reg;
    logic [4:0]  hash_count_reg;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        add_reg, add_next;
    logic [KW-1:0] key_reg, key_next;
    logic [LW-1:0] len_reg, len_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] x_reg, x_next;
    logic [HW-1:0] i_reg, i_next;
    logic [HW-1:0] nh_reg, nh_next;
    logic [31:0] nb_reg, nb_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  step_reg, step_next;
    logic [2:0]  bit_reg, bit_next;
    logic        hit_reg, hit_next;
    logic        rv_reg, rv_next;
    logic        rp_reg, rp_next;

    hash_cmd_t hcmd;
    hash_rsp_t hrsp;

    logic          we;
    logic [AW-1:0] addr;
    logic [7:0]    wdata, rdata;
    logic [32:0]   trial;
    logic [KW-1:0] key_in;
    logic [LW-1:0] len_in;
    logic [31:0]   nb_in;
    logic [HW-1:0] nh_in;
    logic          busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= BIT_COUNT_RST;
            hash_count_reg <= HASH_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_COUNT:  bit_count_reg  <= cfg_wdata;
                CFG_HASH_COUNT: hash_count_reg <= cfg_wdata[4:0];
            endcase
        end
    end

    bfdh_hash #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hcmd),
        .key   (key_reg),
        .len   (len_reg),
        .rsp   (hrsp)
    );

    bfdh_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Request decode: key packing, length and count saturation
    always_comb
    begin
        logic [127:0] k128;
        logic [4:0]   l;
        k128   = {req.data.key_hi, req.data.key_lo};
        key_in = KW'(k128);
        l      = (req.data.key_len > 5'd16) ? 5'd16 : req.data.key_len;
        len_in = (32'(l) > 32'(MAX_KEY_BYTES)) ? LW'(MAX_KEY_BYTES) : LW'(l);
        nb_in  = (bit_count_reg == 17'd0) ? 32'd1 : 32'(bit_count_reg);
        if (nb_in > MAXB)
        begin
            nb_in = MAXB;
        end
        nh_in  = (32'(hash_count_reg) > 32'(MAX_HASHES)) ? HW'(MAX_HASHES)
                                                         : HW'(hash_count_reg);
    end

    assign busy      = (state_reg != S_IDLE) && (state_reg != S_OUT);
    assign req.ready = !busy && (!rv_reg || rsp.ready) && (state_reg == S_IDLE);
    assign rsp.valid = rv_reg;
    assign rsp.data.present = rp_reg;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, nb_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        add_next   = add_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        i_next     = i_reg;
        nh_next    = nh_reg;
        nb_next    = nb_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        hit_next   = hit_reg;
        rv_next    = rv_reg;
        rp_next    = rp_reg;
        hcmd       = '0;
        we         = 1'b0;
        addr       = x_reg[AW+2:3];
        wdata      = rdata | (8'd1 << bit_reg);
        if (rv_reg && rsp.ready)
        begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                addr  = clr_reg;
                wdata = 8'd0;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == 32'(STORE_BYTES - 1))
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE, S_OUT:
            begin
                state_next = S_IDLE;
                if (req.valid && req.ready)
                begin
                    add_next = (req.data.req_type == REQ_ADD);
                    key_next = key_in;
                    len_next = len_in;
                    nb_next  = nb_in;
                    nh_next  = nh_in;
                    i_next   = '0;
                    hit_next = 1'b1;
                    if (req.data.req_type == REQ_CLEAR)
                    begin
                        rv_next = 1'b1; rp_next = 1'b0;
                        state_next = S_CLR;
                    end
                    else if (req.data.req_type == REQ_ADD ||
                             req.data.req_type == REQ_CHECK)
                    begin
                        state_next = S_HA;
                    end
                    else
                    begin
                        rv_next = 1'b1; rp_next = 1'b0;
                    end
                end
            end
            S_HA:
            begin
                // first pass starts once the key is registered
                if (hrsp.done)
                begin
                    a_next     = hrsp.hash;
                    step_next  = '0;
                    state_next = S_HB;
                end
                else if (step_reg == 6'd0)
                begin
                    hcmd.start = 1'b1;
                    hcmd.seed  = FIRST_SEED;
                    step_next  = 6'd1;
                end
            end
            S_HB:
            begin
                // start second pass in the cycle after the first finishes
                if (hrsp.done)
                begin
                    b_next     = hrsp.hash;
                    x_next     = a_reg;
                    state_next = S_PROBE;
                end
                else if (step_reg == 6'd0)
                begin
                    hcmd.start = 1'b1;
                    hcmd.seed  = a_reg;
                    step_next  = 6'd1;
                end
            end
            S_PROBE:
            begin
                step_next = '0;
                if (i_reg == nh_reg)
                begin
                    rv_next = 1'b1; rp_next = hit_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = x_reg;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                // restoring division, one quotient bit a cycle
                if (trial[32])
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                end
                else
                begin
                    rem_next = trial[31:0];
                end
                quo_next  = {quo_reg[30:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31)
                begin
                    x_next     = rem_next;
                    bit_next   = rem_next[2:0];
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                x_next = a_reg + 32'(i_reg + HW'(1)) * b_reg;
                i_next = i_reg + HW'(1);
                step_next = '0;
                if (!rdata[bit_reg])
                begin
                    hit_next = 1'b0;
                    if (add_reg)
                    begin
                        we = 1'b1;
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        rv_next = 1'b1; rp_next = 1'b0;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        add_reg <= add_next;
        key_reg <= key_next;
        len_reg <= len_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        i_reg   <= i_next;
        nh_reg  <= nh_next;
        nb_reg  <= nb_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        hit_reg <= hit_next;
        rp_reg  <= rp_next;
    end
endmodule

// File: test/tb_bloom_filter_double_hash.sv
// Testbench for the double-hash bloom filter: random and directed requests,
// scoreboard with its own hash and bit store model. Depends on bfdh_pkg, bfdh_if and bloom_filter_double_hash.
module tb_bloom_filter_double_hash;
    import bfdh_pkg::*;

    localparam int STORE_BITS = 65536;
    localparam int WATCH_LIMIT = 200000;

    // Scoreboard: own filter state, queue of expected presence bits
    class bloom_scoreboard;
        bit         filter_bits [STORE_BITS];
        logic [16:0] bit_count;
        logic [4:0]  hash_count;
        bit         want_present [$];
        int         fails;

        function new();
            foreach (filter_bits[i]) filter_bits[i] = 0;
            bit_count  = BIT_COUNT_RST;
            hash_count = HASH_COUNT_RST;
            fails = 0;
        endfunction

        function logic [31:0] murmur2(logic [7:0] kb [16], int len, logic [31:0] seed);
            logic [31:0] h, k;
            int pos, rest;
            h = seed ^ len;
            pos = 0;
            rest = len;
            while (rest >= 4)
            begin
                k = {kb[pos + 3], kb[pos + 2], kb[pos + 1], kb[pos]};
                k = k * MM_M;
                k = k ^ (k >> 24);
                k = k * MM_M;
                h = h * MM_M;
                h = h ^ k;
                pos += 4;
                rest -= 4;
            end
            if (rest == 3) h = h ^ ({24'd0, kb[pos + 2]} << 16);
            if (rest >= 2) h = h ^ ({24'd0, kb[pos + 1]} << 8);
            if (rest >= 1)
            begin
                h = h ^ {24'd0, kb[pos]};
                h = h * MM_M;
            end
            h = h ^ (h >> 13);
            h = h * MM_M;
            h = h ^ (h >> 15);
            return h;
        endfunction

        function void note_request(req_t r);
            logic [7:0] kb [16];
            logic [31:0] a, b, x, nbits;
            int len, nhash, hits;
            bit is_add, done;
            if (r.req_type == REQ_CLEAR)
            begin
                foreach (filter_bits[i]) filter_bits[i] = 0;
                want_present.push_back(0);
                return;
            end
            if (r.req_type != REQ_CHECK && r.req_type != REQ_ADD)
            begin
                want_present.push_back(0);
                return;
            end
            for (int j = 0; j < 8; j++)
            begin
                kb[j]     = r.key_lo[8*j +: 8];
                kb[j + 8] = r.key_hi[8*j +: 8];
            end
            len = (r.key_len > 16) ? 16 : r.key_len;
            nbits = (bit_count == 0) ? 1 : ((bit_count > STORE_BITS) ? STORE_BITS : bit_count);
            nhash = (hash_count > 16) ? 16 : hash_count;
            is_add = (r.req_type == REQ_ADD);
            a = murmur2(kb, len, FIRST_SEED);
            b = murmur2(kb, len, a);
            hits = 0;
            done = 0;
            for (int i = 0; i < nhash && !done; i++)
            begin
                x = (a + i * b) % nbits;
                if (filter_bits[x]) hits++;
                else if (is_add) filter_bits[x] = 1;
                else done = 1;
            end
            want_present.push_back(!done && hits == nhash);
        endfunction

        function void check_result(rsp_t r);
            bit w;
            if (want_present.size() == 0)
            begin
                $error("unexpected transaction: present=%0d", r.present);
                fails++;
                return;
            end
            w = want_present.pop_front();
            if (r.present !== w)
            begin
                $error("present: expected %0d actual %0d", w, r.present);
                fails++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = CFG_BIT_COUNT;
    logic [16:0] cfg_wdata = '0;
    int send_idle = 0;
    int recv_stall = 0;
    int quiet = 0;
    bloom_scoreboard sb;

    bfdh_if #(.payload_t(req_t)) req (clk);
    bfdh_if #(.payload_t(rsp_t)) rsp (clk);

    bloom_filter_double_hash dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.data = '0;
    end

    // Sample both channels at each edge, keep the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready) sb.note_request(req.data);
            if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCH_LIMIT)
            begin
                $display("** bloom_filter_double_hash: FAILED **");
                $finish;
            end
        end
    end

    // Receiver stalls at a random rate
    always @(posedge clk)
        rsp.ready <= rst_n && ($urandom_range(99) >= recv_stall);

    task automatic write_reg(logic idx, logic [16:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.bit_count  = (idx == CFG_BIT_COUNT)  ? val : sb.bit_count;
        sb.hash_count = (idx == CFG_HASH_COUNT) ? val[4:0] : sb.hash_count;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (sb.want_present.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // One request; valid stays high across back-to-back transactions
    task automatic send_req(logic [1:0] t, logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
        req_t r;
        r.req_type = t;
        r.key_lo = lo;
        r.key_hi = hi;
        r.key_len = len;
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    task automatic idle_req();
        req.valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly adds and checks, about half of them over a small key pool so hits occur
    task automatic random_phase(int n, int big_clear);
        logic [63:0] pool_lo [8];
        logic [63:0] pool_hi [8];
        logic [4:0]  pool_len [8];
        int k, p;
        for (int i = 0; i < 8; i++)
        begin
            pool_lo[i] = rand64();
            pool_hi[i] = rand64();
            pool_len[i] = 5'($urandom_range(31));
        end
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(99);
            k = $urandom_range(7);
            if (p < 2 && big_clear)
                send_req(REQ_CLEAR, rand64(), rand64(), 5'($urandom_range(31)));
            else if (p < 3)
                send_req(REQ_RSVD, rand64(), rand64(), 5'($urandom_range(31)));
            else if (p < 50)
                send_req(2'($urandom_range(1)), pool_lo[k], pool_hi[k], pool_len[k]);
            else
                send_req(2'($urandom_range(1)), rand64(), rand64(),
                         5'($urandom_range(31)));
        end
        idle_req();
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes of keys and lengths, each request type
        send_req(REQ_CHECK, '0, '0, 5'd0);
        send_req(REQ_ADD, '0, '0, 5'd0);
        send_req(REQ_CHECK, '0, '0, 5'd0);
        send_req(REQ_ADD, '1, '1, 5'd16);
        send_req(REQ_CHECK, '1, '1, 5'd16);
        send_req(REQ_CHECK, '1, '1, 5'd31);
        send_req(REQ_ADD, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1);
        send_req(REQ_ADD, 64'h0123456789abcdef, '0, 5'd2);
        send_req(REQ_ADD, 64'h0123456789abcdef, '0, 5'd3);
        send_req(REQ_CHECK, 64'h0123456789abcdef, '0, 5'd3);
        send_req(REQ_ADD, '1, 64'h5555aaaa5555aaaa, 5'd13);
        send_req(REQ_RSVD, '1, '1, 5'd16);
        send_req(REQ_CLEAR, '0, '0, 5'd0);
        send_req(REQ_CHECK, '1, '1, 5'd16);
        idle_req();
        drain();

        // Small filter, all probes on one bit set: hits counted within a key
        write_reg(CFG_BIT_COUNT, 17'd1);
        write_reg(CFG_HASH_COUNT, 5'd16);
        send_req(REQ_ADD, 64'h42, '0, 5'd4);
        send_req(REQ_CHECK, 64'h77, '0, 5'd8);
        idle_req();
        drain();
        write_reg(CFG_BIT_COUNT, 17'd0);
        write_reg(CFG_HASH_COUNT, 5'd0);
        send_req(REQ_CHECK, rand64(), rand64(), 5'd16);
        send_req(REQ_ADD, rand64(), rand64(), 5'd9);
        idle_req();
        drain();
        write_reg(CFG_BIT_COUNT, 17'h1ffff);
        write_reg(CFG_HASH_COUNT, 5'd31);
        send_req(REQ_ADD, '1, '0, 5'd7);
        send_req(REQ_CHECK, '1, '0, 5'd7);
        idle_req();
        drain();

        // Random phases across settings and idling patterns
        write_reg(CFG_BIT_COUNT, 17'd64);
        write_reg(CFG_HASH_COUNT, 5'd3);
        random_phase(300, 0);
        drain();
        send_idle = 49;
        write_reg(CFG_BIT_COUNT, 17'd1000);
        write_reg(CFG_HASH_COUNT, 5'd5);
        random_phase(300, 0);
        drain();
        send_idle = 0;
        recv_stall = 49;
        write_reg(CFG_BIT_COUNT, 17'd65536);
        write_reg(CFG_HASH_COUNT, 5'd1);
        random_phase(300, 1);
        drain();
        send_idle = 16;
        recv_stall = 16;
        write_reg(CFG_BIT_COUNT, 17'd200);
        write_reg(CFG_HASH_COUNT, 5'd8);
        random_phase(300, 0);
        drain();
        send_idle = 0;
        recv_stall = 0;
        write_reg(CFG_BIT_COUNT, 17'd4093);
        write_reg(CFG_HASH_COUNT, 5'd16);
        random_phase(400, 0);
        drain();
        write_reg(CFG_BIT_COUNT, 17'd31);
        write_reg(CFG_HASH_COUNT, 5'd2);
        random_phase(400, 0);

        // Final wait for outstanding results
        drain();
        if (sb.fails == 0)
            $display("** bloom_filter_double_hash: PASSED **");
        else
            $display("** bloom_filter_double_hash: FAILED **");
        $finish;
    end
endmodule

// File: filelist.f
design/bfdh_pkg.sv
design/bfdh_if.sv
design/bfdh_ram.sv
design/bfdh_hash.sv
design/bloom_filter_double_hash.sv
test/tb_bloom_filter_double_hash.sv
